// ===== src/counting_semaphore_wait_queue_defines.svh =====
// Assertion macros shared by the semaphore checker.
// No dependencies; included by the checker file only.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define CSQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("semaphore checker: property failed");

// Next-cycle implication, disabled while rst is high.
`define CSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("semaphore checker: property failed");

`endif

// ===== src/csq_pkg.sv =====
// Shared types and constants of the counting semaphore with wait queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package csq_pkg;

   // Default sizes of the block
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 8;
   localparam int DEF_COUNT_BITS  = 16;

   // Fixed field widths on the ports
   localparam int OP_W      = 2;
   localparam int REQ_ID_W  = 8;
   localparam int STATUS_W  = 3;
   localparam int WOKEN_W   = 8;
   localparam int COUNT_W   = 16;
   localparam int WAITERS_W = 5;
   localparam int RSP_DATA_W = 32;

   // Operation codes; any code with the high bit set is a destroy check
   localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
   localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_BLOCKED   = 3'd1,
      ST_WOKE      = 3'd2,
      ST_INCR      = 3'd3,
      ST_DESTROYED = 3'd4,
      ST_BUSY      = 3'd5,
      ST_FULL      = 3'd6,
      ST_SATURATED = 3'd7
   } csq_status_type;

   // Outcome of one item, handed from the controller to the output stage
   typedef struct packed {
      csq_status_type         status;
      logic [COUNT_W-1:0]     count_now;
      logic [WAITERS_W-1:0]   waiters_now;
   } csq_decision_type;

endpackage

`default_nettype wire

// ===== src/counting_semaphore_wait_queue.sv =====
// Top level of the counting semaphore with a FIFO wait queue.
// Depends on csq_pkg, csq_ctrl and csq_wait_mem.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_tvalid/req_tready  | tuser: op; tdata: requester_id
//  rsp     | out       | rsp_tvalid/rsp_tready  | tuser: status; tdata: woken, count, waiters
//  csr     | in        | csr_we                 | csr_wdata: initial_count
//
// Each item passes the pending stage, then the output register; state updates
// at the accept edge, and the woken id is read from the queue memory meanwhile.
// No new item is taken while one waits in the single pending stage on the read.
// Reset is synchronous; it clears count, pointers and occupancy.
// A stalled result holds in the output register; req_tready drops meanwhile.
`default_nettype none

module counting_semaphore_wait_queue
   import csq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_ID_W-1:0]   req_tdata,   // [7:0] requester_id
   input  wire logic [OP_W-1:0]       req_tuser,   // [1:0] op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] woken_id, [23:8] count_now,
                                                   // [28:24] waiters_now, [31:29] zero
   output logic [STATUS_W-1:0]        rsp_tuser,   // [2:0] status
   input  wire logic                  csr_we,
   input  wire logic [COUNT_W-1:0]    csr_wdata    // initial_count
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic                  accept;
   logic                  mem_wr_en, mem_rd_en;
   logic [PTR_BITS-1:0]   mem_wr_addr, mem_rd_addr;
   logic [ID_BITS-1:0]    mem_wr_data, mem_rd_data;
   csq_decision_type      decision;

   logic                  pend_ff, pend_in;
   csq_decision_type      pend_dec_ff;
   logic                  out_valid_ff, out_valid_in;
   csq_decision_type      out_dec_ff;
   logic [WOKEN_W-1:0]    out_woken_ff;

   // take an item when nothing is pending and the output frees up
   assign req_tready = !reset && !pend_ff && (!out_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   csq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .PTR_BITS    (PTR_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (accept),
      .item_op     (req_tuser),
      .item_id     (req_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .decision    (decision)
   );

   csq_wait_mem #(
      .DEPTH     (QUEUE_DEPTH),
      .WIDTH     (ID_BITS),
      .ADDR_BITS (PTR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // pending stage and output register valid flags
   always_comb begin
      pend_in      = accept;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (pend_ff) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: decision waits in the pending stage for the queue read
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_dec_ff <= decision;
      end
      if (pend_ff) begin
         out_dec_ff   <= pend_dec_ff;
         out_woken_ff <= (pend_dec_ff.status == ST_WOKE) ? WOKEN_W'(mem_rd_data) : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_dec_ff.status;
   assign rsp_tdata  = {3'b000, out_dec_ff.waiters_now, out_dec_ff.count_now, out_woken_ff};

endmodule

`default_nettype wire

// ===== src/csq_wait_mem.sv =====
// Wait queue storage: one write port, one read port, registered read data.
// Depends on csq_pkg.
`default_nettype none

module csq_wait_mem
   import csq_pkg::*;
#(
   parameter int DEPTH     = DEF_QUEUE_DEPTH,
   parameter int WIDTH     = DEF_ID_BITS,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/csq_ctrl.sv =====
// Semaphore controller: count, queue pointers, occupancy and per-item decision.
// Depends on csq_pkg; drives the ports of csq_wait_mem.
`default_nettype none

module csq_ctrl
   import csq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS,
   parameter int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire logic [OP_W-1:0]     item_op,
   input  wire logic [REQ_ID_W-1:0] item_id,
   input  wire logic                csr_we,
   input  wire logic [COUNT_W-1:0]  csr_wdata,
   output logic                     mem_wr_en,
   output logic [PTR_BITS-1:0]      mem_wr_addr,
   output logic [ID_BITS-1:0]       mem_wr_data,
   output logic                     mem_rd_en,
   output logic [PTR_BITS-1:0]      mem_rd_addr,
   output csq_decision_type         decision
);

   localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [OCC_BITS-1:0]   OCC_FULL = OCC_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0]   PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_W-1:0]    init_ff, init_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, item_count;
   logic [PTR_BITS-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   csq_status_type        item_status;
   logic                  push, pop;

   // decide one item from the current state
   always_comb begin
      item_count  = count_ff;
      item_status = ST_BUSY;
      push        = 1'b0;
      pop         = 1'b0;
      unique case (item_op)
         OP_WAIT: begin
            if (count_ff != '0) begin
               item_count  = count_ff - 1'b1;
               item_status = ST_GRANTED;
            end else if (occ_ff == OCC_FULL) begin
               item_status = ST_FULL;
            end else begin
               push        = 1'b1;
               item_status = ST_BLOCKED;
            end
         end
         OP_SIGNAL: begin
            if (occ_ff != '0) begin
               pop         = 1'b1;
               item_status = ST_WOKE;
            end else if (count_ff == COUNT_MAX) begin
               item_status = ST_SATURATED;
            end else begin
               item_count  = count_ff + 1'b1;
               item_status = ST_INCR;
            end
         end
         default: begin
            // destroy check
            if (occ_ff != '0) begin
               item_status = ST_BUSY;
            end else begin
               item_count  = COUNT_BITS'(init_ff);
               item_status = ST_DESTROYED;
            end
         end
      endcase
   end

   // next state; a register write reloads the count
   always_comb begin
      init_in  = csr_we ? csr_wdata : init_ff;
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      if (item_valid) begin
         count_in = item_count;
         if (push) begin
            tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            occ_in  = occ_ff + 1'b1;
         end
         if (pop) begin
            head_in = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
            occ_in  = occ_ff - 1'b1;
         end
      end
      if (csr_we) begin
         count_in = COUNT_BITS'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff  <= '0;
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         init_ff  <= init_in;
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         occ_ff   <= occ_in;
      end
   end

   // queue accesses: push at tail, read head on a wake
   assign mem_wr_en   = item_valid && push;
   assign mem_wr_addr = tail_ff;
   assign mem_wr_data = ID_BITS'(item_id);
   assign mem_rd_en   = item_valid && pop;
   assign mem_rd_addr = head_ff;

   assign decision.status      = item_status;
   assign decision.count_now   = COUNT_W'(item_count);
   assign decision.waiters_now = WAITERS_W'(occ_in);

endmodule

`default_nettype wire

// ===== src/csq_checker.sv =====
// Port-level checker for the counting semaphore, bound to the top level.
// Depends on csq_pkg and counting_semaphore_wait_queue_defines.svh.
`include "counting_semaphore_wait_queue_defines.svh"
`default_nettype none

module csq_checker
   import csq_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [STATUS_W-1:0]   rsp_tuser
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // a stalled result stays offered
   `CSQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // reset empties the output
   `CSQ_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)

   // every accepted item shows its result after the pending stage and output register
   `CSQ_ASSERT_IMPLY(a_item_result, clock, reset, req_fire, ##2 rsp_tvalid)

   // woken id is zero unless a waiter was woken
   `CSQ_ASSERT_IMPLY(a_woken_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_WOKE, rsp_tdata[7:0] == 8'd0)

endmodule

bind counting_semaphore_wait_queue csq_checker u_csq_checker (.*);

`default_nettype wire
